// ===== rtl/gme_pkg.sv =====
// Package for the gradient magnitude edge detector.
// Holds field widths, register map, queue item type and back end states.
// No dependencies.
package gme_pkg;

    localparam int PIX_W = 8;
    localparam int LW_W  = 11;
    localparam int FH_W  = 16;

    localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    localparam int ROOT_W     = 9;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 1;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    typedef struct packed {
        logic [PIX_W-1:0] dv;
        logic [PIX_W-1:0] dh;
        logic             eof;
    } gme_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } gme_qstat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SQUARE,
        BK_ROOT,
        BK_OUT
    } gme_back_state_t;

endpackage

// ===== rtl/gme_front.sv =====
// Front end: pixel intake, row and column counters, line store, clamped differences.
// Depends on gme_pkg.
module gme_front
    import gme_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    output logic             pixel_stall,
    input  logic [PIX_W-1:0] pixel,
    input  logic [LW_W-1:0]  line_width,
    input  logic [FH_W-1:0]  frame_height,
    input  gme_qstat_t       q_stat,
    output logic             q_push,
    output gme_item_t        q_item
);

    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int MAX_W = $clog2(MAX_WIDTH + 1);
    localparam int CW    = (MAX_W > LW_W) ? MAX_W : LW_W;

    logic [PIX_W-1:0] line_mem [MAX_WIDTH];

    logic [CB-1:0]    column_count_reg, column_count_next;
    logic [FH_W-1:0]  row_count_reg, row_count_next;
    logic [PIX_W-1:0] left_pixel_reg;
    logic             stage_valid_reg, stage_valid_next;
    logic [PIX_W-1:0] pix_b_reg;
    logic [PIX_W-1:0] left_b_reg;
    logic [PIX_W-1:0] above_reg;
    logic             zero_b_reg;
    logic             eof_b_reg;

    logic             accept;
    logic [CW-1:0]    lw_ext;
    logic [CW-1:0]    max_ext;
    logic [CW-1:0]    eff_w;
    logic [CW-1:0]    col_ext;
    logic [CW-1:0]    col_sel;
    logic [CB-1:0]    col_idx;
    logic [FH_W-1:0]  eff_h;
    logic             last_col;
    logic             last_row;
    logic [PIX_W-1:0] dv;
    logic [PIX_W-1:0] dh;

    assign pixel_stall = stage_valid_reg && q_stat.full;
    assign accept      = pixel_valid && !pixel_stall;
    assign q_push      = stage_valid_reg && !q_stat.full;

    always_comb
    begin
        lw_ext  = CW'(line_width);
        max_ext = CW'(MAX_WIDTH);
        if (line_width == '0)
        begin
            eff_w = CW'(1);
        end
        else if (lw_ext > max_ext)
        begin
            eff_w = max_ext;
        end
        else
        begin
            eff_w = lw_ext;
        end
        col_ext = CW'(column_count_reg);
        col_sel = (col_ext >= eff_w) ? (eff_w - CW'(1)) : col_ext;
        col_idx = col_sel[CB-1:0];
        eff_h   = (frame_height == '0) ? FH_W'(1) : frame_height;
        last_col = (col_sel == (eff_w - CW'(1)));
        last_row = (row_count_reg >= (eff_h - FH_W'(1)));

        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (accept)
        begin
            if (last_col)
            begin
                column_count_next = '0;
                row_count_next    = last_row ? '0 : (row_count_reg + FH_W'(1));
            end
            else
            begin
                column_count_next = col_idx + CB'(1);
            end
        end

        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            left_pixel_reg   <= '0;
            stage_valid_reg  <= 1'b0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            stage_valid_reg  <= stage_valid_next;
            if (accept)
            begin
                left_pixel_reg <= pixel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            above_reg         <= line_mem[col_idx];
            line_mem[col_idx] <= pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_b_reg  <= pixel;
            left_b_reg <= left_pixel_reg;
            zero_b_reg <= (row_count_reg == '0) || (col_sel == '0);
            eof_b_reg  <= last_col && last_row;
        end
    end

    always_comb
    begin
        dv = (pix_b_reg > above_reg) ? (pix_b_reg - above_reg) : '0;
        dh = (pix_b_reg > left_b_reg) ? (pix_b_reg - left_b_reg) : '0;
        q_item.dv  = zero_b_reg ? '0 : dv;
        q_item.dh  = zero_b_reg ? '0 : dh;
        q_item.eof = eof_b_reg;
    end

endmodule

// ===== rtl/gme_queue.sv =====
// Two-entry request queue between front end and back end.
// Depends on gme_pkg.
module gme_queue
    import gme_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  gme_item_t  push_item,
    input  logic       pop,
    output gme_item_t  pop_item,
    output gme_qstat_t stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    gme_item_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
        stat.empty = (count_reg == '0);
        pop_item   = entry_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : (wr_ptr_reg + PTR_W'(1));
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : (rd_ptr_reg + PTR_W'(1));
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/gme_back.sv =====
// Back end: sum of squares, two passes of a bit-serial square root, output register.
// Depends on gme_pkg.
module gme_back
    import gme_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  gme_qstat_t       q_stat,
    input  gme_item_t        q_item,
    output logic             q_pop,
    output logic             edge_valid,
    input  logic             edge_stall,
    output logic [PIX_W-1:0] edge_value,
    output logic             end_of_frame
);

    gme_back_state_t   state_reg, state_next;
    logic [PIX_W-1:0]  dv_reg, dv_next;
    logic [PIX_W-1:0]  dh_reg, dh_next;
    logic              eof_reg, eof_next;
    logic              pass_reg, pass_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  out_value_reg, out_value_next;
    logic              out_eof_reg, out_eof_next;

    logic [2*PIX_W-1:0] sq_dv;
    logic [2*PIX_W-1:0] sq_dh;
    logic [RAD_W-1:0]   sq_m;
    logic [REM_W+1:0]   rem_shift;
    logic [REM_W+1:0]   trial;
    logic               root_ge;

    assign edge_valid   = out_valid_reg;
    assign edge_value   = out_value_reg;
    assign end_of_frame = out_eof_reg;

    always_comb
    begin
        sq_dv     = (2*PIX_W)'(dv_reg) * (2*PIX_W)'(dv_reg);
        sq_dh     = (2*PIX_W)'(dh_reg) * (2*PIX_W)'(dh_reg);
        sq_m      = RAD_W'(root_reg) * RAD_W'(root_reg);
        rem_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        root_ge   = (rem_shift >= trial);

        state_next     = state_reg;
        dv_next        = dv_reg;
        dh_next        = dh_reg;
        eof_next       = eof_reg;
        pass_next      = pass_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        out_value_next = out_value_reg;
        out_eof_next   = out_eof_reg;
        out_valid_next = out_valid_reg && edge_stall;
        q_pop          = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop      = 1'b1;
                    dv_next    = q_item.dv;
                    dh_next    = q_item.dh;
                    eof_next   = q_item.eof;
                    pass_next  = 1'b0;
                    state_next = BK_SQUARE;
                end
            end
            BK_SQUARE:
            begin
                if (pass_reg)
                begin
                    rad_next = sq_m >> 1;
                end
                else
                begin
                    rad_next = RAD_W'(sq_dv) + RAD_W'(sq_dh);
                end
                rem_next   = '0;
                root_next  = '0;
                step_next  = '0;
                state_next = BK_ROOT;
            end
            BK_ROOT:
            begin
                rem_next  = root_ge ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
                root_next = {root_reg[ROOT_W-2:0], root_ge};
                rad_next  = rad_reg << 2;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    if (!pass_reg)
                    begin
                        pass_next  = 1'b1;
                        state_next = BK_SQUARE;
                    end
                    else
                    begin
                        state_next = BK_OUT;
                    end
                end
            end
            BK_OUT:
            begin
                if (!out_valid_reg || !edge_stall)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = root_reg[PIX_W-1:0];
                    out_eof_next   = eof_reg;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_reg        <= dv_next;
        dh_reg        <= dh_next;
        eof_reg       <= eof_next;
        pass_reg      <= pass_next;
        rad_reg       <= rad_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        step_reg      <= step_next;
        out_value_reg <= out_value_next;
        out_eof_reg   <= out_eof_next;
    end

endmodule

// ===== rtl/gradient_magnitude_edge_detector.sv =====
// Top level of the gradient magnitude edge detector: register port and block wiring.
// Depends on gme_pkg, gme_front, gme_queue and gme_back.
//
// Pixels enter in raster order; each gives one result, floor(floor(sqrt(dv^2+dh^2))/sqrt2)
// of the clamped vertical and horizontal backward differences, and 0 in row 0 and column 0.
// A pixel is registered in the front end and then handled by the back end, whose single
// bit-serial square root unit runs twice per pixel at one result bit per cycle, so the
// back end takes a pixel only when idle. A two-entry queue lets the front end take
// pixels while the back end works. The line store needs no clearing after reset. Write
// line_width (address 0) and frame_height (address 4) only while the block is idle.
module gradient_magnitude_edge_detector
    import gme_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  logic [PIX_W-1:0]      pixel,
    output logic                  edge_valid,
    input  logic                  edge_stall,
    output logic [PIX_W-1:0]      edge_value,
    output logic                  end_of_frame
);

    logic [LW_W-1:0]      line_width_reg;
    logic [FH_W-1:0]      frame_height_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 reg_write;

    logic       q_push;
    logic       q_pop;
    gme_item_t  q_push_item;
    gme_item_t  q_pop_item;
    gme_qstat_t q_stat;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= LINE_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (reg_write)
        begin
            case (reg_idx)
                REG_LINE_WIDTH:   line_width_reg   <= pwdata[LW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FH_W-1:0];
                default:          line_width_reg   <= line_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_LINE_WIDTH:   prdata = APB_DATA_W'(line_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    gme_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .line_width   (line_width_reg),
        .frame_height (frame_height_reg),
        .q_stat       (q_stat),
        .q_push       (q_push),
        .q_item       (q_push_item)
    );

    gme_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .pop_item  (q_pop_item),
        .stat      (q_stat)
    );

    gme_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .q_item       (q_pop_item),
        .q_pop        (q_pop),
        .edge_valid   (edge_valid),
        .edge_stall   (edge_stall),
        .edge_value   (edge_value),
        .end_of_frame (end_of_frame)
    );

`ifndef SYNTH
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("request pushed into full queue");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("request popped from empty queue");

    a_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
        edge_valid |-> (edge_value <= 8'd254))
        else $error("edge value above largest scaled magnitude");
`endif

endmodule

// ===== dv/gradient_magnitude_edge_detector_tb.sv =====
// Self-checking testbench for gradient_magnitude_edge_detector: directed and random pixel
// streams, register writes over the APB port, random stalls, bit-exact edge prediction.
// Depends on gme_pkg and the gradient_magnitude_edge_detector RTL.
module gradient_magnitude_edge_detector_tb
    import gme_pkg::*;
();

    localparam int LINE_MAX = 1024;
    localparam logic [APB_ADDR_W-1:0] ADDR_LINE_WIDTH   = {REG_LINE_WIDTH, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_FRAME_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};
    localparam int RANDOM_PIXELS = 560;
    localparam int DRAIN_CYCLES  = 32;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_CAP    = 50;

    typedef struct {
        logic [PIX_W-1:0] mag;
        logic             eof;
    } edge_result_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  pixel_valid  = 1'b0;
    logic                  pixel_stall;
    logic [PIX_W-1:0]      pixel        = '0;
    logic                  edge_valid;
    logic                  edge_stall   = 1'b0;
    logic [PIX_W-1:0]      edge_value;
    logic                  end_of_frame;

    edge_result_t pending_edges[$];
    int unsigned  error_count    = 0;
    bit           quiet_run      = 1'b0;
    logic         receiver_hold  = 1'b0;
    int unsigned  stall_run      = 0;
    bit           stall_now;

    logic [LW_W-1:0]  cfg_width  = LINE_WIDTH_RST;
    logic [FH_W-1:0]  cfg_height = FRAME_HEIGHT_RST;
    logic [PIX_W-1:0] line_above [LINE_MAX];
    bit               col_written [LINE_MAX];
    logic [PIX_W-1:0] left_px    = '0;
    int unsigned      col_cnt    = 0;
    int unsigned      row_cnt    = 0;
    logic [PIX_W-1:0] last_px    = '0;

    gradient_magnitude_edge_detector #(.MAX_WIDTH(LINE_MAX)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .edge_valid   (edge_valid),
        .edge_stall   (edge_stall),
        .edge_value   (edge_value),
        .end_of_frame (end_of_frame)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (error_count < REPORT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int unsigned floor_root(input int unsigned v);
        int unsigned r;
        int unsigned t;
        r = 0;
        for (int b = 15; b >= 0; b--)
        begin
            t = r | (32'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic int unsigned clamped_width(input logic [LW_W-1:0] w_raw);
        if (w_raw == 0)
            return 1;
        if (w_raw > LINE_MAX)
            return LINE_MAX;
        return 32'(w_raw);
    endfunction

    function automatic bit width_reads_written(input logic [LW_W-1:0] w_raw);
        int unsigned w;
        w = clamped_width(w_raw);
        if (row_cnt == 0)
            return 1'b1;
        for (int i = 1; i < w; i++)
        begin
            if (!col_written[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic compute_edge(input logic [PIX_W-1:0] px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int unsigned  dv;
        int unsigned  dh;
        int unsigned  m;
        edge_result_t r;
        w = clamped_width(cfg_width);
        h = (cfg_height == 0) ? 1 : 32'(cfg_height);
        c = (col_cnt >= w) ? w - 1 : col_cnt;
        r.mag = '0;
        if (row_cnt != 0 && c != 0)
        begin
            dv = (px > line_above[c]) ? 32'(px) - 32'(line_above[c]) : 0;
            dh = (px > left_px) ? 32'(px) - 32'(left_px) : 0;
            m = floor_root(dv * dv + dh * dh);
            r.mag = PIX_W'(floor_root((m * m) >> 1));
        end
        line_above[c] = px;
        col_written[c] = 1'b1;
        left_px = px;
        r.eof = (c + 1 >= w) && (row_cnt + 1 >= h);
        if (c + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        end
        else
            col_cnt = c + 1;
        pending_edges.push_back(r);
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet_run)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input int unsigned style);
        logic [PIX_W-1:0] v;
        int unsigned      s;
        s = (style == 3) ? $urandom_range(0, 2) : style;
        case (s)
            0: v = PIX_W'($urandom);
            1: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: v = PIX_W'(int'(last_px) + int'($urandom_range(0, 8)) - 4);
        endcase
        last_px = v;
        return v;
    endfunction

    task automatic check_edge();
        edge_result_t want;
        if (pending_edges.size() == 0)
        begin
            report_mismatch($sformatf("result with none pending: edge_value=%0d eof=%0b",
                                      edge_value, end_of_frame));
            return;
        end
        want = pending_edges.pop_front();
        if (edge_value !== want.mag)
            report_mismatch($sformatf("edge_value %0d, want %0d", edge_value, want.mag));
        if (end_of_frame !== want.eof)
            report_mismatch($sformatf("end_of_frame %b, want %b", end_of_frame, want.eof));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && edge_valid && !edge_stall)
            check_edge();
        stall_now = 1'b0;
        if (stall_run == 0)
            stall_run = pick_gap();
        if (stall_run != 0)
        begin
            stall_now = 1'b1;
            stall_run--;
        end
        edge_stall <= receiver_hold || stall_now;
    end

    task automatic send_pixel(input logic [PIX_W-1:0] v);
        int unsigned gap;
        pixel_valid <= 1'b1;
        pixel <= v;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        compute_edge(v);
        gap = pick_gap();
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        pixel_valid <= 1'b0;
        while (pending_edges.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_LINE_WIDTH)
            cfg_width = data[LW_W-1:0];
        else if (addr == ADDR_FRAME_HEIGHT)
            cfg_height = data[FH_W-1:0];
    endtask

    task automatic read_register(input logic [APB_ADDR_W-1:0] addr,
                                 input logic [APB_DATA_W-1:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
            report_mismatch($sformatf("register at %0d reads %h, want %h", addr, prdata, want));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_geometry(input logic [LW_W-1:0] w, input logic [FH_W-1:0] h);
        write_register(ADDR_LINE_WIDTH, APB_DATA_W'(w));
        write_register(ADDR_FRAME_HEIGHT, APB_DATA_W'(h));
        read_register(ADDR_LINE_WIDTH, APB_DATA_W'(w));
        read_register(ADDR_FRAME_HEIGHT, APB_DATA_W'(h));
    endtask

    task automatic test_border_and_extremes();
        logic [PIX_W-1:0] pattern [12];
        pattern = '{8'd10, 8'd200, 8'd0, 8'd255,
                    8'd0, 8'd255, 8'd255, 8'd0,
                    8'd0, 8'd255, 8'd0, 8'd128};
        read_register(ADDR_LINE_WIDTH, APB_DATA_W'(LINE_WIDTH_RST));
        read_register(ADDR_FRAME_HEIGHT, APB_DATA_W'(FRAME_HEIGHT_RST));
        set_geometry(11'd4, 16'd3);
        foreach (pattern[i])
            send_pixel(pattern[i]);
        drain();
    endtask

    task automatic test_zero_geometry();
        set_geometry(11'd0, 16'd0);
        repeat (3) send_pixel(pick_pixel(0));
        drain();
        set_geometry(11'd0, 16'd3);
        repeat (3) send_pixel(pick_pixel(0));
        drain();
    endtask

    task automatic test_mid_frame_change();
        set_geometry(11'd4, 16'd3);
        repeat (6) send_pixel(pick_pixel(1));
        drain();
        set_geometry(11'd2, 16'd2);
        repeat (3) send_pixel(pick_pixel(0));
        drain();
        set_geometry(11'd4, 16'hFFFF);
        repeat (3) send_pixel(pick_pixel(1));
        drain();
    endtask

    task automatic test_widest_line();
        quiet_run <= 1'b1;
        set_geometry(11'h7FF, 16'hFFFF);
        repeat (LINE_MAX + 30) send_pixel(pick_pixel(3));
        drain();
        set_geometry(11'd8, 16'd4);
        repeat (20) send_pixel(pick_pixel(3));
        drain();
        quiet_run <= 1'b0;
    endtask

    task automatic test_output_hold();
        set_geometry(11'd5, 16'd3);
        fork
            begin
                receiver_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                receiver_hold <= 1'b0;
            end
            repeat (30) send_pixel(pick_pixel(0));
        join
        drain();
    endtask

    task automatic test_random_streams();
        logic [LW_W-1:0] w;
        logic [FH_W-1:0] h;
        int unsigned     r;
        int unsigned     phase_len;
        int unsigned     style;
        int unsigned     sent;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                w = '0;
            else if (r < 12)
                w = LW_W'($urandom_range(LINE_MAX - 8, 2047));
            else if (r < 25)
                w = LW_W'($urandom_range(13, 64));
            else
                w = LW_W'($urandom_range(1, 12));
            r = $urandom_range(0, 99);
            if (r < 8)
                h = '0;
            else if (r < 80)
                h = FH_W'($urandom_range(1, 8));
            else if (r < 90)
                h = 16'hFFFF;
            else
                h = FH_W'($urandom_range(9, 300));
            if (!width_reads_written(w))
                w = cfg_width;
            quiet_run <= ($urandom_range(0, 5) == 0);
            set_geometry(w, h);
            phase_len = $urandom_range(20, 120);
            style = $urandom_range(0, 3);
            repeat (phase_len) send_pixel(pick_pixel(style));
            sent += phase_len;
            drain();
        end
        quiet_run <= 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_border_and_extremes();
        test_zero_geometry();
        test_mid_frame_change();
        test_output_hold();
        test_widest_line();
        test_random_streams();
        drain();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #12000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
